// ----- src/xtea_ecb_byte_stream_encryptor_macros.svh -----
// Assertion macros shared by the encryptor modules.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef XTEA_ECB_BYTE_STREAM_ENCRYPTOR_MACROS_SVH
`define XTEA_ECB_BYTE_STREAM_ENCRYPTOR_MACROS_SVH
`ifndef SYNTHESIS
// The condition holds at every clock edge.
`define XTEA_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// The consequent holds in the same cycle as the antecedent.
`define XTEA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define XTEA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define XTEA_ASSERT_HOLDS(label, cond, msg)
`define XTEA_ASSERT_IMPL(label, ante, cons, msg)
`define XTEA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- src/xtea_pkg.sv -----
package xtea_pkg;

   // XTEA key schedule constant.
   localparam logic [31:0] DELTA = 32'h9E3779B9;

   // Block geometry.
   localparam int unsigned BLOCK_BITS = 64;
   localparam logic [2:0] LAST_BYTE = 3'd7;

   // Queue between the byte packer and the cipher.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   // Configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_ZERO = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_ONE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_TWO = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_THREE = 3'd3;

   // The 128-bit key as four 32-bit words, word 0 in the low lane.
   typedef logic [3:0][31:0] key_type;

   // One plaintext or ciphertext block with its end-of-message flag.
   typedef struct packed {
      logic [BLOCK_BITS-1:0] block;
      logic                  last;
   } blk_type;

   // Cipher sequencer states.
   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_RUN,
      CORE_DONE
   } core_state_type;

   // The XTEA mixing term: ((v << 4) ^ (v >> 5)) + v.
   function automatic logic [31:0] mix(logic [31:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

endpackage

// ----- src/xtea_ecb_byte_stream_encryptor.sv -----
// XTEA byte-stream encryptor, ECB mode. Plaintext enters one byte per item, low byte of
// each 32-bit word first, with req_final_byte on the last byte of a message; a partial
// final block is padded with bytes equal to the pad count. Each block leaves as eight
// cipher items in the same byte order, rsp_block_end on the eighth and rsp_message_end
// on the eighth of the final block. The cipher runs one full XTEA cycle per clock and
// takes no new block until its result is taken; that iterative round unit sets the rate.
// A two-entry queue between the byte packer and the cipher, and the output serializer,
// let input bytes keep flowing while a block is encrypted or drained. The key is written
// through the csr port (index 0 to 3, other indexes ignored); the user must write it only
// while the block is idle, and the block itself does not enforce this. No clearing pass
// is needed after reset.
module xtea_ecb_byte_stream_encryptor #(
   parameter int CIPHER_CYCLES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_plain_byte,
   input  logic                              req_final_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_cipher_byte,
   output logic                              rsp_block_end,
   output logic                              rsp_message_end,
   input  logic                              csr_write_enable,
   input  logic [xtea_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [xtea_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   xtea_pkg::key_type key_ff, key_in;
   xtea_pkg::blk_type push_item;
   xtea_pkg::blk_type head_item;
   xtea_pkg::blk_type ct_item;
   logic queue_full;
   logic push;
   logic pop;
   logic head_valid;
   logic ct_valid;
   logic ct_ready;

   // Key register writes.
   always_comb begin
      key_in = key_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            xtea_pkg::CSR_KEY_WORD_ZERO:  key_in[0] = csr_write_data;
            xtea_pkg::CSR_KEY_WORD_ONE:   key_in[1] = csr_write_data;
            xtea_pkg::CSR_KEY_WORD_TWO:   key_in[2] = csr_write_data;
            xtea_pkg::CSR_KEY_WORD_THREE: key_in[3] = csr_write_data;
            default: begin
               key_in = key_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // Front: gather bytes into blocks and pad the last one.
   xtea_packer u_packer (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_plain_byte (req_plain_byte),
      .req_final_byte (req_final_byte),
      .queue_full     (queue_full),
      .push           (push),
      .push_item      (push_item)
   );

   // Blocks waiting for the cipher.
   xtea_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Back: iterative XTEA rounds.
   xtea_core #(
      .CIPHER_CYCLES (CIPHER_CYCLES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .key       (key_ff),
      .in_valid  (head_valid),
      .in_item   (head_item),
      .in_pop    (pop),
      .out_valid (ct_valid),
      .out_item  (ct_item),
      .out_ready (ct_ready)
   );

   // Back: cipher bytes out one per item.
   xtea_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (ct_valid),
      .in_item         (ct_item),
      .in_ready        (ct_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cipher_byte (rsp_cipher_byte),
      .rsp_block_end   (rsp_block_end),
      .rsp_message_end (rsp_message_end)
   );

endmodule

// ----- src/xtea_packer.sv -----
module xtea_packer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_plain_byte,
   input  logic               req_final_byte,
   input  logic               queue_full,
   output logic               push,
   output xtea_pkg::blk_type  push_item
);

   logic [2:0]  count_ff, count_in;
   logic [63:0] block_ff, block_in;
   logic [63:0] assembled;
   logic        accept;
   logic        complete;
   logic [7:0]  pad_byte;

   // An item is taken whenever the queue can hold a finished block.
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign complete  = accept && ((count_ff == xtea_pkg::LAST_BYTE) || req_final_byte);

   // Pad bytes carry the number of bytes missing from the block.
   assign pad_byte = {5'd0, 3'(xtea_pkg::LAST_BYTE - count_ff)};

   // Build the block: stored bytes below the fill point, the new byte at it, pad above.
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         if (3'(k) < count_ff) begin
            assembled[8*k +: 8] = block_ff[8*k +: 8];
         end else if (3'(k) == count_ff) begin
            assembled[8*k +: 8] = req_plain_byte;
         end else begin
            assembled[8*k +: 8] = pad_byte;
         end
      end
   end

   assign push      = complete;
   assign push_item = '{block: assembled, last: req_final_byte};

   // Next fill count and block contents.
   always_comb begin
      count_in = count_ff;
      block_in = block_ff;
      if (complete) begin
         count_in = '0;
      end else if (accept) begin
         count_in = count_ff + 3'd1;
      end
      if (accept) begin
         block_in = assembled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
   end

endmodule

// ----- src/xtea_queue.sv -----
`include "xtea_ecb_byte_stream_encryptor_macros.svh"

module xtea_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  xtea_pkg::blk_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output xtea_pkg::blk_type  head_item
);

   localparam int unsigned PW = xtea_pkg::QUEUE_PTR_W;
   localparam int unsigned CW = xtea_pkg::QUEUE_CNT_W;
   localparam logic [PW-1:0] PTR_LAST = PW'(xtea_pkg::QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH = CW'(xtea_pkg::QUEUE_DEPTH);

   xtea_pkg::blk_type entries_ff [xtea_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == DEPTH);
   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   `XTEA_ASSERT_IMPL(a_no_overflow, push, count_ff < DEPTH, "block pushed into a full queue")
   `XTEA_ASSERT_IMPL(a_no_underflow, pop, count_ff != '0, "block popped from an empty queue")

endmodule

// ----- src/xtea_core.sv -----
`include "xtea_ecb_byte_stream_encryptor_macros.svh"

module xtea_core #(
   parameter int CIPHER_CYCLES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  xtea_pkg::key_type  key,
   input  logic               in_valid,
   input  xtea_pkg::blk_type  in_item,
   output logic               in_pop,
   output logic               out_valid,
   output xtea_pkg::blk_type  out_item,
   input  logic               out_ready
);

   localparam int unsigned RW = $clog2(CIPHER_CYCLES + 1);
   localparam logic [RW-1:0] LAST_ROUND = RW'(CIPHER_CYCLES - 1);

   xtea_pkg::core_state_type state_ff, state_in;
   logic [RW-1:0] round_ff, round_in;
   logic [31:0]   v0_ff, v0_in;
   logic [31:0]   v1_ff, v1_in;
   logic [31:0]   sum_ff, sum_in;
   logic          last_ff, last_in;
   logic [31:0]   sum_next;
   logic [31:0]   v0_new;
   logic [31:0]   v1_new;
   logic          load;

   // One full XTEA cycle: both half rounds in one clock.
   assign sum_next = sum_ff + xtea_pkg::DELTA;
   assign v0_new = v0_ff + (xtea_pkg::mix(v1_ff) ^ (sum_ff + key[sum_ff[1:0]]));
   assign v1_new = v1_ff + (xtea_pkg::mix(v0_new) ^ (sum_next + key[sum_next[12:11]]));

   assign out_valid = (state_ff == xtea_pkg::CORE_DONE);
   assign out_item  = '{block: {v1_ff, v0_ff}, last: last_ff};
   assign in_pop    = load;

   // Sequencer: load a block, run the rounds, hold the result until it is taken.
   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      unique case (state_ff)
         xtea_pkg::CORE_IDLE: begin
            if (in_valid) begin
               load     = 1'b1;
               state_in = xtea_pkg::CORE_RUN;
            end
         end
         xtea_pkg::CORE_RUN: begin
            if (round_ff == LAST_ROUND) begin
               state_in = xtea_pkg::CORE_DONE;
            end
         end
         xtea_pkg::CORE_DONE: begin
            if (out_ready) begin
               if (in_valid) begin
                  load     = 1'b1;
                  state_in = xtea_pkg::CORE_RUN;
               end else begin
                  state_in = xtea_pkg::CORE_IDLE;
               end
            end
         end
         default: begin
            state_in = xtea_pkg::CORE_IDLE;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      round_in = round_ff;
      v0_in    = v0_ff;
      v1_in    = v1_ff;
      sum_in   = sum_ff;
      last_in  = last_ff;
      if (load) begin
         round_in = '0;
         v0_in    = in_item.block[31:0];
         v1_in    = in_item.block[63:32];
         sum_in   = '0;
         last_in  = in_item.last;
      end else if (state_ff == xtea_pkg::CORE_RUN) begin
         round_in = round_ff + RW'(1);
         v0_in    = v0_new;
         v1_in    = v1_new;
         sum_in   = sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xtea_pkg::CORE_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      v0_ff   <= v0_in;
      v1_ff   <= v1_in;
      sum_ff  <= sum_in;
      last_ff <= last_in;
   end

   // The counter rests one past the last round while the result waits.
   `XTEA_ASSERT_NEXT(a_result_held, out_valid && !out_ready,
      out_valid && $stable(v0_ff) && $stable(v1_ff), "cipher result changed while waiting")
   `XTEA_ASSERT_HOLDS(a_round_bound, round_ff <= RW'(CIPHER_CYCLES), "round counter out of range")

endmodule

// ----- src/xtea_serializer.sv -----
`include "xtea_ecb_byte_stream_encryptor_macros.svh"

module xtea_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  xtea_pkg::blk_type  in_item,
   output logic               in_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_cipher_byte,
   output logic               rsp_block_end,
   output logic               rsp_message_end
);

   logic        valid_ff, valid_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] data_ff, data_in;
   logic        last_ff, last_in;
   logic        take;
   logic        final_take;
   logic        load;

   assign take       = valid_ff && rsp_ready;
   assign final_take = take && (idx_ff == xtea_pkg::LAST_BYTE);
   assign in_ready   = !valid_ff || final_take;
   assign load       = in_valid && in_ready;

   assign rsp_valid       = valid_ff;
   assign rsp_cipher_byte = data_ff[7:0];
   assign rsp_block_end   = (idx_ff == xtea_pkg::LAST_BYTE);
   assign rsp_message_end = (idx_ff == xtea_pkg::LAST_BYTE) && last_ff;

   // Shift the block out low byte first; a new block loads as the last byte leaves.
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
         data_in  = in_item.block;
         last_in  = in_item.last;
      end else if (take) begin
         valid_in = !final_take;
         idx_in   = idx_ff + 3'd1;
         data_in  = data_ff >> 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   `XTEA_ASSERT_NEXT(a_drain_empty, final_take && !in_valid, !rsp_valid,
      "serializer still valid after its last byte left")

endmodule
